// ----- rtl/core/tfa_pkg.sv -----
// Shared types, codes and constants of the temporal frame averager.
package tfa_pkg;

  localparam int IDX_W      = 12;
  localparam int IDX_MAX    = 4095;
  localparam int VAL_W      = 8;
  localparam int AVG_W      = 8;
  localparam int MODE_W     = 2;
  localparam int NUM_W      = 4;
  localparam int NUM_MAX    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PIXELS_DEF     = 4096;
  localparam int PIXEL_BITS_DEF = 8;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GEOM  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;

  localparam logic [NUM_W-1:0] FRAMES_RESET = 4'd8;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] pixel_index;
    logic [VAL_W-1:0] pixel_value;
    logic             end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] average_value;
    logic [IDX_W-1:0] result_index;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NUM_W-1:0]  frames;
  } ring_cfg_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Number of compare-subtract steps that bring any pixel index below pixels.
  function automatic int mod_steps(input int pixels);
    int k;
    k = 0;
    for (int i = 0; i < IDX_W; i++) begin
      if ((longint'(pixels) << i) <= longint'(IDX_MAX)) k = i + 1;
    end
    return k;
  endfunction

  function automatic logic [IDX_W-1:0] mod_top(input int pixels);
    int k;
    k = mod_steps(pixels);
    return (k > 0) ? IDX_W'(longint'(pixels) << (k - 1)) : '0;
  endfunction

endpackage

// ----- rtl/core/tfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tfa_alu.sv -----
// Shared add/subtract unit with unsigned compare result.
module tfa_alu #(
  parameter int W = 12
) (
  input  tfa_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             ge
);
  import tfa_pkg::*;

  logic         is_sub;
  logic [W-1:0] b_eff;
  logic [W:0]   total;

  assign is_sub = (op == ALU_SUB);
  assign b_eff  = is_sub ? ~b : b;
  assign total  = {1'b0, a} + {1'b0, b_eff} + (W + 1)'(is_sub);
  assign res    = total[W-1:0];
  assign ge     = total[W];

endmodule

// ----- rtl/core/tfa_seq.sv -----
// Item sequencer: index reduction, store, ring walk, division, rounding and clearing sweep.
module tfa_seq #(
  parameter int MAX_FRAMES = tfa_pkg::MAX_FRAMES_DEF,
  parameter int PIXELS     = tfa_pkg::PIXELS_DEF,
  parameter int PIXEL_BITS = tfa_pkg::PIXEL_BITS_DEF,
  parameter int ADDR_W     = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  tfa_pkg::in_item_t     item,
  input  tfa_pkg::ring_cfg_t    ring_cfg,
  input  logic                  ring_clr,
  output logic                  busy,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output logic [PIXEL_BITS-1:0] mem_wdata,
  output logic [ADDR_W-1:0]     mem_raddr,
  input  logic [PIXEL_BITS-1:0] mem_rdata,
  output logic                  out_strobe,
  output tfa_pkg::out_item_t    out_item
);
  import tfa_pkg::*;

  localparam int SLOT_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int POS_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int DEPTH     = MAX_FRAMES << POS_W;
  localparam int CW        = imax(SLOT_W, NUM_W);
  localparam int ALU_W     = imax(IDX_W, PIXEL_BITS + NUM_W);
  localparam int MOD_STEPS = mod_steps(PIXELS);
  localparam logic [IDX_W-1:0] MOD_TOP = mod_top(PIXELS);
  localparam int STEP_MAX  = imax(NUM_MAX, imax(PIXEL_BITS, MOD_STEPS));
  localparam int CNT_W     = $clog2(STEP_MAX + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_STORE,
    S_FETCH,
    S_WAIT,
    S_DIV,
    S_ROUND
  } state_t;

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0]     ws_r, ws_nxt;
  logic [SLOT_W-1:0]     rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  op_r, op_nxt;
  logic                  eof_r, eof_nxt;
  logic [VAL_W-1:0]      val_r, val_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [ALU_W-1:0]      acc_r, acc_nxt;
  logic [PIXEL_BITS-1:0] quo_r, quo_nxt;
  logic [ALU_W-1:0]      dvs_r, dvs_nxt;
  logic                  half_r, half_nxt;
  logic                  sticky_r, sticky_nxt;
  logic                  first_r, first_nxt;
  logic                  vld_r, vld_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_item_r, out_item_nxt;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_ge;

  logic             begin_op;
  logic             op_now;
  logic             is_mean;
  logic             round_up;
  logic [POS_W-1:0] pos;
  logic [NUM_W:0]   two_rem;
  logic [NUM_W:0]   n_ext;

  tfa_alu #(
    .W (ALU_W)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [NUM_W-1:0]  num);
    logic [CW-1:0] nx;
    nx = CW'(s) + CW'(1);
    return (nx == CW'(num)) ? '0 : SLOT_W'(nx);
  endfunction

  assign pos     = POS_W'(pos_r);
  assign is_mean = (ring_cfg.mode != MODE_HALVE) && (ring_cfg.mode != MODE_GEOM);
  assign two_rem = {acc_r[NUM_W-1:0], 1'b0};
  assign n_ext   = {1'b0, ring_cfg.frames};

  always_comb begin
    if (is_mean) begin
      round_up = (two_rem > n_ext) || ((two_rem == n_ext) && quo_r[0]);
    end else begin
      round_up = half_r && (sticky_r || acc_r[0]);
    end
  end

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_STORE);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : ADDR_W'({ws_r, pos});
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : PIXEL_BITS'(val_r);
  assign mem_raddr = ADDR_W'({rd_slot_r, pos});

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    ws_nxt         = ws_r;
    rd_slot_nxt    = rd_slot_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    eof_nxt        = eof_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    half_nxt       = half_r;
    sticky_nxt     = sticky_r;
    first_nxt      = first_r;
    vld_nxt        = 1'b0;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    alu_op         = ALU_ADD;
    alu_a          = acc_r;
    alu_b          = ALU_W'(mem_rdata);
    begin_op       = 1'b0;
    op_now         = op_r;

    // fold the frame read last cycle into the running value
    if (vld_r) begin
      first_nxt = 1'b0;
      if (is_mean || ((ring_cfg.mode == MODE_HALVE) && first_r)) begin
        acc_nxt = alu_res;
      end else begin
        acc_nxt    = alu_res >> 1;
        half_nxt   = alu_res[0];
        sticky_nxt = sticky_r | half_r;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (go) begin
          op_nxt  = item.op;
          eof_nxt = item.end_of_frame;
          val_nxt = item.pixel_value;
          idx_nxt = item.pixel_index;
          pos_nxt = item.pixel_index;
          dvs_nxt = ALU_W'(MOD_TOP);
          cnt_nxt = CNT_W'(MOD_STEPS - 1);
          op_now  = item.op;
          if (MOD_STEPS == 0) begin
            begin_op = 1'b1;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(pos_r);
        alu_b  = dvs_r;
        if (alu_ge) begin
          pos_nxt = IDX_W'(alu_res);
        end
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          begin_op = 1'b1;
        end
      end
      S_STORE: begin
        if (eof_r) begin
          ws_nxt = slot_inc(ws_r, ring_cfg.frames);
        end
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        vld_nxt     = 1'b1;
        rd_slot_nxt = slot_inc(rd_slot_r, ring_cfg.frames);
        cnt_nxt     = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (is_mean) begin
          state_nxt = S_DIV;
          dvs_nxt   = ALU_W'(ring_cfg.frames) << (PIXEL_BITS - 1);
          cnt_nxt   = CNT_W'(PIXEL_BITS - 1);
          quo_nxt   = '0;
        end else begin
          state_nxt = S_ROUND;
        end
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = acc_r;
        alu_b  = dvs_r;
        if (alu_ge) begin
          acc_nxt = alu_res;
        end
        quo_nxt = PIXEL_BITS'({quo_r, alu_ge});
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        alu_op                     = ALU_ADD;
        alu_a                      = is_mean ? ALU_W'(quo_r) : acc_r;
        alu_b                      = ALU_W'(round_up);
        out_strobe_nxt             = 1'b1;
        out_item_nxt.average_value = AVG_W'(alu_res);
        out_item_nxt.result_index  = idx_r;
        state_nxt                  = S_IDLE;
      end
    endcase

    if (begin_op) begin
      if (op_now == OP_STORE) begin
        state_nxt = S_STORE;
      end else begin
        state_nxt   = S_FETCH;
        rd_slot_nxt = ws_r;
        cnt_nxt     = CNT_W'(ring_cfg.frames) - CNT_W'(1);
        acc_nxt     = '0;
        half_nxt    = 1'b0;
        sticky_nxt  = 1'b0;
        first_nxt   = 1'b1;
      end
    end

    // restart the sweep and rewind the ring
    if (ring_clr) begin
      state_nxt    = S_CLEAR;
      clr_addr_nxt = '0;
      ws_nxt       = '0;
      vld_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      ws_r         <= '0;
      vld_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      ws_r         <= ws_nxt;
      vld_r        <= vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_item_r   <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_slot_nxt;
    cnt_r     <= cnt_nxt;
    op_r      <= op_nxt;
    eof_r     <= eof_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    acc_r     <= acc_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    half_r    <= half_nxt;
    sticky_r  <= sticky_nxt;
    first_r   <= first_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- rtl/core/temporal_frame_averager.sv -----
// Top level of the temporal frame averager: configuration registers, frame store, sequencer.
//
// Channel  Ports                                    Transfer
// input    start, busy, in_item                     item taken when start is high, busy low
// result   out_strobe, out_item                     item valid for the one strobe cycle
// config   cfg_valid, cfg_ready, cfg_index, cfg_data write taken when valid and ready high
//
// A store item keeps busy high through the store state; a read with N frames keeps it high
// through N frame fetches, a wait, PIXEL_BITS quotient bits in modes 0 and 3 and rounding, set
// by the single add/subtract unit: one frame fetched per cycle, one quotient bit per cycle.
// PIXELS below 4096 adds one index-reduction step per cycle on that same unit.
// Reset and every frames_in_use write run a clearing sweep of MAX_FRAMES * 2^ceil(log2 PIXELS)
// words (32768 by default) with busy high. Results cannot be stalled; cfg_ready stays high.
module temporal_frame_averager #(
  parameter int MAX_FRAMES = tfa_pkg::MAX_FRAMES_DEF,
  parameter int PIXELS     = tfa_pkg::PIXELS_DEF,
  parameter int PIXEL_BITS = tfa_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  tfa_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output tfa_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tfa_pkg::*;

  localparam int POS_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int DEPTH  = MAX_FRAMES << POS_W;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FR_W   = imax(NUM_W, $clog2(MAX_FRAMES + 1));

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [NUM_W-1:0]  frames_r, frames_nxt;
  logic [NUM_W-1:0]  ring_len;
  logic              cfg_wr;
  logic              ring_clr;
  logic              seq_busy;
  logic              go;
  ring_cfg_t         ring_cfg;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [PIXEL_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [PIXEL_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign ring_clr  = cfg_wr && (cfg_index == REG_FRAMES_IN_USE);

  always_comb begin
    mode_nxt   = mode_r;
    frames_nxt = frames_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_AVERAGE_MODE:  mode_nxt   = cfg_data[MODE_W-1:0];
        REG_FRAMES_IN_USE: frames_nxt = cfg_data[NUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MEAN;
      frames_r <= FRAMES_RESET;
    end else begin
      mode_r   <= mode_nxt;
      frames_r <= frames_nxt;
    end
  end

  always_comb begin
    priority if (frames_r == '0) begin
      ring_len = NUM_W'(1);
    end else if (FR_W'(frames_r) > FR_W'(MAX_FRAMES)) begin
      ring_len = NUM_W'(MAX_FRAMES);
    end else begin
      ring_len = frames_r;
    end
  end

  assign ring_cfg.mode   = mode_r;
  assign ring_cfg.frames = ring_len;

  assign go   = start && !seq_busy;
  assign busy = seq_busy;

  tfa_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tfa_seq #(
    .MAX_FRAMES (MAX_FRAMES),
    .PIXELS     (PIXELS),
    .PIXEL_BITS (PIXEL_BITS),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .item       (in_item),
    .ring_cfg   (ring_cfg),
    .ring_clr   (ring_clr),
    .busy       (seq_busy),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
